// ===== rtl/awo_pkg.sv =====
// ----------------------------------------------------------------------------
// awo_pkg
// Shared types, codes and elaboration helpers for the additive oscillator.
// ----------------------------------------------------------------------------
package awo_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_WAVEFORM  = 3'd0;
    localparam logic [2:0] CFG_PHASE_INC = 3'd1;
    localparam logic [2:0] CFG_HARMONICS = 3'd2;
    localparam logic [2:0] CFG_DUTY      = 3'd3;
    localparam logic [2:0] CFG_QBITS     = 3'd4;
    localparam logic [2:0] CFG_AMPLITUDE = 3'd5;

    // waveform codes
    localparam logic [2:0] WAVE_SINE  = 3'd0;
    localparam logic [2:0] WAVE_QSQ   = 3'd1;
    localparam logic [2:0] WAVE_BSQ   = 3'd2;
    localparam logic [2:0] WAVE_SAW   = 3'd3;
    localparam logic [2:0] WAVE_BSAW  = 3'd4;

    localparam int ROM_W  = 24;   // Q22 sine entry, signed
    localparam int MAG_W  = 23;   // magnitude of a sine entry
    localparam int ACC_W  = 32;   // Q22 sum
    localparam int LV_W   = 17;   // quantizer level count
    localparam int PW     = ACC_W + LV_W + 1;
    localparam int DW     = 48;   // divider dividend magnitude
    localparam int DVW    = 17;   // divider divisor
    localparam int STEP_W = 6;
    localparam int QW     = DW + 1;

    // gain stage: floor(m / 800) = floor((m >> 5) / 25), m below 2^35,
    // the divide by 25 done as a multiply by ceil(2^35 / 25) and a shift
    localparam int GMW     = 35;          // gain product magnitude
    localparam int GNW     = GMW - 5;     // magnitude after the shift by 5
    localparam int GRW     = 31;          // reciprocal width
    localparam int GAIN_SH = 35;
    localparam int GQW     = 26;          // gain quotient
    localparam logic [GRW-1:0] GAIN_RECIP = 31'd1374389535;

    typedef struct packed {
        logic              start;
        logic [DW-1:0]     mag;
        logic [STEP_W-1:0] steps;
        logic [DVW-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quo;
        logic          rem_nz;
    } t_div_rsp;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_ADDR  = 12'b0000_0000_0010,
        ST_LOAD  = 12'b0000_0000_0100,
        ST_DIV   = 12'b0000_0000_1000,
        ST_ACC   = 12'b0000_0001_0000,
        ST_QMUL  = 12'b0000_0010_0000,
        ST_QLOAD = 12'b0000_0100_0000,
        ST_QDIV  = 12'b0000_1000_0000,
        ST_AMUL  = 12'b0001_0000_0000,
        ST_ALOAD = 12'b0010_0000_0000,
        ST_ADIV  = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } t_state;

    // sin(u*pi/2), u and result Q30; elaboration only
    function automatic longint unsigned quarter_sine(longint unsigned u);
        longint unsigned one;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        one = 64'd1 << 30;
        x   = (u * 64'd1686629713) >> 30;
        x2  = (x * x) >> 30;
        t   = one - x2 / 110;
        t   = one - ((x2 * t) >> 30) / 72;
        t   = one - ((x2 * t) >> 30) / 42;
        t   = one - ((x2 * t) >> 30) / 20;
        t   = one - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

endpackage

// ===== rtl/additive_waveform_oscillator.sv =====
// ----------------------------------------------------------------------------
// additive_waveform_oscillator
// Phase-accumulator oscillator: sine, sawtooth, band-limited sawtooth and
// square (plain and level-quantized) built from a sine ROM and one divider.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  input    | in        | i_valid / o_ready   | i_restart_phase
//  output   | out       | o_valid / i_ready   | o_sample (Q4.19)
//  config   | in        | i_cfg_we            | i_cfg_addr, i_cfg_data
//
// One sample per input transfer. Each harmonic term is a ROM read, a
// 23-step serial divide by the harmonic number and an accumulate; a
// quantized square adds a divide by the level count, and the gain (divide
// by 800 as a reciprocal multiply) ends every sample. A sine takes one
// term, a sawtooth none, a band sawtooth H, a band square three per
// harmonic for H-1 harmonics. Reset is synchronous, active low,
// and clears the phase and loads register defaults. A result waiting on
// the output does not block a new transfer in; the sequencer only stalls
// at its last step until the output register is free.
// The sine ROM depth must be a power of two.
// ----------------------------------------------------------------------------
module additive_waveform_oscillator #(
    parameter int MAX_HARMONICS    = 64,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_restart_phase,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [23:0] o_sample,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);
    import awo_pkg::*;

    localparam int LG      = $clog2(SINE_TABLE_DEPTH);
    localparam int HW      = $clog2(MAX_HARMONICS + 1);
    localparam int SH_DOWN = (PHASE_BITS >= 22) ? PHASE_BITS - 22 : 0;
    localparam int SH_UP   = (PHASE_BITS < 22) ? 22 - PHASE_BITS : 0;

    typedef logic signed [ROM_W-1:0] t_rom [SINE_TABLE_DEPTH];
    typedef logic [PHASE_BITS-1:0] t_duty_tab [21];

    // sine ROM contents, built at elaboration
    function automatic t_rom build_rom();
        t_rom            tab;
        longint unsigned f;
        longint unsigned quad;
        longint unsigned u;
        longint unsigned s;
        longint unsigned v;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            f    = longint'(i) << (32 - LG);
            quad = (f >> 30) & 64'd3;
            u    = f & ((64'd1 << 30) - 64'd1);
            if (quad[0])
                u = (64'd1 << 30) - u;
            s = quarter_sine(u);
            v = (s + 64'd128) >> 8;
            tab[i] = (quad >= 64'd2) ? -ROM_W'(v) : ROM_W'(v);
        end
        return tab;
    endfunction

    // duty angle per twentieth
    function automatic t_duty_tab build_duty();
        t_duty_tab tab;
        for (int d = 0; d < 21; d++)
            tab[d] = PHASE_BITS'((longint'(d) << PHASE_BITS) / 20);
        return tab;
    endfunction

    localparam t_rom      SINE_ROM = build_rom();
    localparam t_duty_tab DUTY_TAB = build_duty();

    // configuration registers
    logic [2:0]  r_wave;
    logic [31:0] r_inc;
    logic [6:0]  r_harm_cfg;
    logic [4:0]  r_duty;
    logic [4:0]  r_qbits;
    logic [6:0]  r_amp;

    // datapath / sequencer
    t_state                   r_state;
    logic [2:0]               r_mode;
    logic [PHASE_BITS-1:0]    r_phase;
    logic [PHASE_BITS-1:0]    r_base [3];
    logic [PHASE_BITS-1:0]    r_ang  [3];
    logic [1:0]               r_term;
    logic [HW-1:0]            r_harm;
    logic [HW-1:0]            r_lim;
    logic signed [ROM_W-1:0]  r_rom_q;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PW-1:0]     r_prod;
    logic                     r_neg;
    logic                     r_out_valid;
    logic signed [23:0]       r_sample;
    logic [GMW-1:0]           r_gmag;
    logic [GQW-1:0]           r_gquo;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // effective (clamped) settings
    logic [HW-1:0]           h_eff;
    logic [4:0]              d_eff;
    logic [4:0]              b_eff;
    logic [LV_W-1:0]         lv;
    logic [6:0]              amp_eff;
    logic [PHASE_BITS-1:0]   ph_start;
    logic [PHASE_BITS-1:0]   dph;
    logic [HW-1:0]           lim_start;
    logic signed [ACC_W-1:0] saw;
    logic                    is_square;
    logic [LG-1:0]           rom_addr;
    logic [ROM_W-1:0]        rom_mag;
    logic signed [PW-1:0]    qdvd;
    logic signed [PW-1:0]    sel_dvd;
    logic signed [PW-1:0]    neg_dvd;
    logic signed [QW-1:0]    trunc_q;
    logic signed [QW-1:0]    floor_q;
    logic [GNW+GRW-1:0]      gain_prod;
    logic [GMW-1:0]          gq800;
    logic                    g_rem_nz;
    logic [GQW+1:0]          g_mag;
    logic signed [GQW+1:0]   g_floor;
    logic signed [23:0]      sat_q;

    assign h_eff   = (int'(r_harm_cfg) > MAX_HARMONICS) ? HW'(MAX_HARMONICS) : HW'(r_harm_cfg);
    assign d_eff   = (r_duty > 5'd20) ? 5'd20 : r_duty;
    assign b_eff   = (r_qbits == 5'd0) ? 5'd1 : ((r_qbits > 5'd16) ? 5'd16 : r_qbits);
    assign lv      = (LV_W'(1) << b_eff) - LV_W'(1);
    assign amp_eff = (r_amp > 7'd100) ? 7'd100 : r_amp;
    assign ph_start = i_restart_phase ? '0 : r_phase;
    assign dph     = DUTY_TAB[d_eff];
    assign is_square = (r_mode == WAVE_QSQ) || (r_mode == WAVE_BSQ);

    // 2*p - 1 in Q22
    assign saw = $signed((ACC_W'(ph_start >> SH_DOWN) << SH_UP) << 1) - $signed(ACC_W'(1) << 22);

    always_comb begin
        case (r_wave)
            WAVE_SINE:           lim_start = HW'(1);
            WAVE_BSAW:           lim_start = h_eff;
            WAVE_QSQ, WAVE_BSQ:  lim_start = (h_eff == '0) ? '0 : h_eff - HW'(1);
            default:             lim_start = '0;
        endcase
    end

    assign rom_addr = r_ang[r_term][PHASE_BITS-1 -: LG];
    assign rom_mag  = r_rom_q[ROM_W-1] ? ROM_W'(-r_rom_q) : ROM_W'(r_rom_q);

    // floor(x / 2^22) * 2^22 by clearing the low bits
    assign qdvd    = {r_prod[PW-1:22], 22'b0};
    assign sel_dvd = (r_state == ST_QLOAD) ? qdvd : r_prod;
    assign neg_dvd = -sel_dvd;

    always_comb begin
        div_req = '0;
        unique case (r_state)
            ST_LOAD: begin
                div_req.start   = 1'b1;
                div_req.mag     = {rom_mag[MAG_W-1:0], {(DW-MAG_W){1'b0}}};
                div_req.steps   = STEP_W'(MAG_W);
                div_req.divisor = DVW'(r_harm);
            end
            ST_QLOAD: begin
                div_req.start   = 1'b1;
                div_req.mag     = sel_dvd[PW-1] ? DW'(neg_dvd) : DW'(sel_dvd);
                div_req.steps   = STEP_W'(DW);
                div_req.divisor = DVW'(lv);
            end
            default: div_req = '0;
        endcase
    end

    awo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign trunc_q = r_neg ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
    assign floor_q = trunc_q - QW'(r_neg && div_rsp.rem_nz);

    // gain: quotient by reciprocal, remainder check by q*800 = q*(512+256+32)
    assign gain_prod = (GNW+GRW)'(r_gmag[GMW-1:5]) * (GNW+GRW)'(GAIN_RECIP);
    assign gq800     = (GMW'(r_gquo) << 9) + (GMW'(r_gquo) << 8) + (GMW'(r_gquo) << 5);
    assign g_rem_nz  = (gq800 != r_gmag);
    assign g_mag     = {2'b00, r_gquo} + (GQW+2)'(r_neg && g_rem_nz);
    assign g_floor   = r_neg ? -$signed(g_mag) : $signed(g_mag);
    assign sat_q     = (g_floor > (GQW+2)'(8388607))  ? 24'sd8388607 :
                       (g_floor < -(GQW+2)'(8388608)) ? -24'sd8388608 : g_floor[23:0];

    // sine ROM, registered read
    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE_ROM[rom_addr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave     <= WAVE_SINE;
            r_inc      <= '0;
            r_harm_cfg <= 7'd2;
            r_duty     <= 5'd10;
            r_qbits    <= 5'd4;
            r_amp      <= 7'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WAVEFORM:  r_wave     <= i_cfg_data[2:0];
                CFG_PHASE_INC: r_inc      <= i_cfg_data;
                CFG_HARMONICS: r_harm_cfg <= i_cfg_data[6:0];
                CFG_DUTY:      r_duty     <= i_cfg_data[4:0];
                CFG_QBITS:     r_qbits    <= i_cfg_data[4:0];
                CFG_AMPLITUDE: r_amp      <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: load from the last step, clear on transfer
            if ((r_state == ST_OUT) && (!r_out_valid || i_ready))
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_phase <= ph_start + PHASE_BITS'(r_inc);
                        r_state <= ((r_wave == WAVE_SAW) || (lim_start == '0)) ? ST_AMUL
                                                                               : ST_ADDR;
                    end
                end
                ST_ADDR: r_state <= ST_LOAD;
                ST_LOAD: r_state <= ST_DIV;
                ST_DIV:  if (div_rsp.done) r_state <= ST_ACC;
                ST_ACC: begin
                    if (is_square && (r_term != 2'd2))
                        r_state <= ST_ADDR;
                    else if (r_harm == r_lim)
                        r_state <= (r_mode == WAVE_QSQ) ? ST_QMUL : ST_AMUL;
                    else
                        r_state <= ST_ADDR;
                end
                ST_QMUL:  r_state <= ST_QLOAD;
                ST_QLOAD: r_state <= ST_QDIV;
                ST_QDIV:  if (div_rsp.done) r_state <= ST_AMUL;
                ST_AMUL:  r_state <= ST_ALOAD;
                ST_ALOAD: r_state <= ST_ADIV;
                ST_ADIV:  r_state <= ST_OUT;
                ST_OUT: begin
                    if (!r_out_valid || i_ready)
                        r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_mode    <= r_wave;
                r_base[0] <= ph_start;
                r_base[1] <= ph_start - dph;
                r_base[2] <= -dph;
                r_ang[0]  <= ph_start;
                r_ang[1]  <= ph_start - dph;
                r_ang[2]  <= -dph;
                r_term    <= 2'd0;
                r_harm    <= HW'(1);
                r_lim     <= lim_start;
                r_acc     <= (r_wave == WAVE_SAW) ? saw : '0;
            end
            ST_LOAD: r_neg <= r_rom_q[ROM_W-1];
            ST_ACC: begin
                // square: + shifted term, - plain term, - offset term
                if (is_square && (r_term != 2'd1))
                    r_acc <= r_acc - ACC_W'(trunc_q);
                else
                    r_acc <= r_acc + ACC_W'(trunc_q);
                if (is_square && (r_term != 2'd2)) begin
                    r_term <= r_term + 2'd1;
                end else begin
                    r_term <= 2'd0;
                    r_harm <= r_harm + HW'(1);
                    for (int k = 0; k < 3; k++)
                        r_ang[k] <= r_ang[k] + r_base[k];
                end
            end
            ST_QMUL:  r_prod <= PW'(r_acc * $signed({1'b0, lv}));
            ST_QLOAD: r_neg  <= qdvd[PW-1];
            ST_QDIV:  if (div_rsp.done) r_acc <= ACC_W'(floor_q);
            ST_AMUL:  r_prod <= PW'(r_acc * $signed({1'b0, amp_eff}));
            ST_ALOAD: begin
                r_neg  <= r_prod[PW-1];
                r_gmag <= sel_dvd[PW-1] ? GMW'(neg_dvd) : GMW'(sel_dvd);
            end
            ST_ADIV:  r_gquo <= gain_prod[GAIN_SH +: GQW];
            ST_OUT:   if (!r_out_valid || i_ready) r_sample <= sat_q;
            default: ;
        endcase
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

endmodule

// ===== rtl/awo_div.sv =====
// ----------------------------------------------------------------------------
// awo_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module awo_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  awo_pkg::t_div_req i_req,
    output awo_pkg::t_div_rsp o_rsp
);
    import awo_pkg::*;

    logic [DW-1:0]     r_dvd;
    logic [DW-1:0]     r_quo;
    logic [DVW-1:0]    r_rem;
    logic [DVW-1:0]    r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVW:0] shifted;
    logic [DVW:0] diff;
    logic         ge;

    assign shifted = {r_rem, r_dvd[DW-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == STEP_W'(1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.mag;
            r_quo <= '0;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_cnt <= i_req.steps;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[DVW-1:0] : shifted[DVW-1:0];
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quo    = r_quo;
    assign o_rsp.rem_nz = |r_rem;

endmodule

// ===== bench/tb_additive_waveform_oscillator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_additive_waveform_oscillator
// Self-checking bench: a directed stimulus table, then random sample ticks
// across register settings, with every output sample predicted and compared.
// ----------------------------------------------------------------------------
module tb_additive_waveform_oscillator;
    import awo_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int HARM_MAX    = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_restart_phase;
    logic        o_valid;
    logic        i_ready;
    logic signed [23:0] o_sample;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;

    additive_waveform_oscillator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_restart_phase(i_restart_phase),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample       (o_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    // predictor state and register shadow
    int signed   sine_rom [TABLE_DEPTH];
    logic [2:0]  wave_sel;
    logic [31:0] phase_step;
    logic [6:0]  harm_cnt;
    logic [4:0]  duty_20;
    logic [4:0]  qbits;
    logic [6:0]  gain_pct;
    logic [31:0] osc_phase;

    logic signed [23:0] pending_samples[$];
    int err_count;
    int sent_count;
    int got_count;
    int cfg_count;
    bit rx_hold;            // long receiver stall in progress

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #300_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // sine table, rebuilt here from the integer Taylor series (Q30 -> Q22)
    function automatic longint unsigned qsin(longint unsigned u);
        longint unsigned one, x, x2, t;
        one = 64'd1 << 30;
        x   = (u * 64'd1686629713) >> 30;
        x2  = (x * x) >> 30;
        t   = one - x2 / 110;
        t   = one - ((x2 * t) >> 30) / 72;
        t   = one - ((x2 * t) >> 30) / 42;
        t   = one - ((x2 * t) >> 30) / 20;
        t   = one - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    task automatic build_rom();
        longint unsigned f, quad, u;
        int v;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            f    = (longint'(i) << 32) / TABLE_DEPTH;
            quad = (f >> 30) & 3;
            u    = f & ((64'd1 << 30) - 1);
            if (quad[0]) u = (64'd1 << 30) - u;
            v = int'((qsin(u) + 128) >> 8);
            sine_rom[i] = (quad >= 2) ? -v : v;
        end
    endtask

    function automatic longint rom_at(logic [31:0] ang);
        return longint'(sine_rom[ang >> 22]);
    endfunction

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint square_accum(int h);
        logic [31:0] dph, shifted;
        longint acc;
        int d;
        acc = 0;
        d   = (duty_20 > 20) ? 20 : duty_20;
        dph = 32'((longint'(d) << 32) / 20);
        shifted = osc_phase - dph;
        for (int i = 1; i < h; i++)
            acc += rom_at(32'(shifted * i)) / i - rom_at(32'(osc_phase * i)) / i
                   - rom_at(32'((32'd0 - dph) * i)) / i;
        return acc;
    endfunction

    // next output sample for one tick; advances the shadow phase
    function automatic logic signed [23:0] next_sample(logic restart);
        int h, amp, b;
        longint v, s, lv, k;
        h   = (harm_cnt > HARM_MAX) ? HARM_MAX : harm_cnt;
        amp = (gain_pct > 100) ? 100 : gain_pct;
        v   = 0;
        if (restart) osc_phase = '0;
        case (wave_sel)
            WAVE_SINE: v = rom_at(osc_phase);
            WAVE_QSQ: begin
                b  = (qbits < 1) ? 1 : ((qbits > 16) ? 16 : qbits);
                lv = (longint'(1) << b) - 1;
                k  = fdiv(square_accum(h) * lv, longint'(1) << 22);
                v  = fdiv(k * (longint'(1) << 22), lv);
            end
            WAVE_BSQ:  v = square_accum(h);
            WAVE_SAW:  v = 2 * longint'(osc_phase >> 10) - (longint'(1) << 22);
            WAVE_BSAW: for (int i = 1; i <= h; i++) v += rom_at(32'(osc_phase * i)) / i;
            default:   v = 0;
        endcase
        s = fdiv(v * amp, 800);
        if (s > 8388607) s = 8388607;
        if (s < -8388608) s = -8388608;
        osc_phase = osc_phase + phase_step;
        return 24'(s);
    endfunction

    task automatic report(string what, logic signed [23:0] got, logic signed [23:0] want);
        $display("mismatch %s: got %0d want %0d (sample %0d)", what, got, want, got_count);
        err_count++;
    endtask

    // register write, only while idle; the caller drops the enable after a group
    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            CFG_WAVEFORM:  wave_sel   = data[2:0];
            CFG_PHASE_INC: phase_step = data;
            CFG_HARMONICS: harm_cnt   = data[6:0];
            CFG_DUTY:      duty_20    = data[4:0];
            CFG_QBITS:     qbits      = data[4:0];
            CFG_AMPLITUDE: gain_pct   = data[6:0];
            default: ;
        endcase
        cfg_count++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // one tick transfer; optional gap first, then hold valid until accepted
    task automatic send_tick(logic restart, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_restart_phase <= restart;
        do @(posedge i_clk); while (!o_ready);
        pending_samples.push_back(next_sample(restart));
        sent_count++;
    endtask

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // output side: random backpressure plus one long hold-off
    initial begin
        int n;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                i_ready <= 1'b0;
                for (n = 0; n < 3000; n++) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            i_ready <= ($urandom_range(0, 99) < 70) || (got_count % 97 < 20);
        end
    end

    // checker: sample outputs at the edge, compare with oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_samples.size() == 0) begin
                report("unexpected", o_sample, 24'sd0);
            end else begin
                logic signed [23:0] want;
                want = pending_samples.pop_front();
                if (o_sample !== want) report("sample", o_sample, want);
            end
            got_count++;
        end
    end

    // directed rows: waveform, increment, harmonics, duty, qbits, amp, restart
    typedef struct {
        logic [2:0]  wv;
        logic [31:0] inc;
        logic [6:0]  hc;
        logic [4:0]  dt;
        logic [4:0]  qb;
        logic [6:0]  ap;
        logic        rs;
        bit          known;
        logic signed [23:0] want;
    } t_row;

    t_row dir_rows[] = '{
        '{WAVE_SINE, 32'd0,          7'd2,   5'd10, 5'd4,  7'd50,  1'b0, 1'b1, 24'sd0},
        '{WAVE_SAW,  32'd0,          7'd2,   5'd10, 5'd4,  7'd100, 1'b1, 1'b1, -24'sd524288},
        '{WAVE_SAW,  32'h8000_0000,  7'd2,   5'd10, 5'd4,  7'd0,   1'b1, 1'b1, 24'sd0},
        '{3'd5,      32'h1234_5678,  7'd5,   5'd10, 5'd4,  7'd100, 1'b0, 1'b1, 24'sd0},
        '{3'd7,      32'hFFFF_FFFF,  7'd5,   5'd10, 5'd4,  7'd127, 1'b1, 1'b1, 24'sd0},
        '{WAVE_BSAW, 32'h0100_0000,  7'd0,   5'd10, 5'd4,  7'd100, 1'b1, 1'b1, 24'sd0},
        '{WAVE_BSQ,  32'h0100_0000,  7'd0,   5'd10, 5'd4,  7'd100, 1'b0, 1'b1, 24'sd0},
        '{WAVE_SINE, 32'h4000_0000,  7'd2,   5'd10, 5'd4,  7'd127, 1'b1, 1'b0, 24'sd0},
        '{WAVE_SINE, 32'hFFFF_FFFF,  7'd2,   5'd10, 5'd4,  7'd100, 1'b0, 1'b0, 24'sd0},
        '{WAVE_SAW,  32'hFFFF_FFFF,  7'd2,   5'd10, 5'd4,  7'd100, 1'b0, 1'b0, 24'sd0},
        '{WAVE_BSAW, 32'h0337_0000,  7'd64,  5'd10, 5'd4,  7'd100, 1'b0, 1'b0, 24'sd0},
        '{WAVE_BSAW, 32'h0A00_0000,  7'd127, 5'd10, 5'd4,  7'd100, 1'b0, 1'b0, 24'sd0},
        '{WAVE_BSQ,  32'h0500_0000,  7'd64,  5'd0,  5'd4,  7'd100, 1'b1, 1'b0, 24'sd0},
        '{WAVE_BSQ,  32'h0500_0000,  7'd33,  5'd20, 5'd4,  7'd100, 1'b0, 1'b0, 24'sd0},
        '{WAVE_BSQ,  32'h0500_0000,  7'd17,  5'd31, 5'd4,  7'd100, 1'b0, 1'b0, 24'sd0},
        '{WAVE_BSQ,  32'h0777_0000,  7'd1,   5'd5,  5'd4,  7'd100, 1'b0, 1'b0, 24'sd0},
        '{WAVE_QSQ,  32'h0900_0000,  7'd20,  5'd7,  5'd0,  7'd100, 1'b1, 1'b0, 24'sd0},
        '{WAVE_QSQ,  32'h0900_0000,  7'd20,  5'd7,  5'd1,  7'd100, 1'b0, 1'b0, 24'sd0},
        '{WAVE_QSQ,  32'h0900_0000,  7'd64,  5'd13, 5'd16, 7'd100, 1'b0, 1'b0, 24'sd0},
        '{WAVE_QSQ,  32'h0900_0000,  7'd64,  5'd13, 5'd31, 7'd127, 1'b0, 1'b0, 24'sd0}
    };

    initial begin
        t_row r;
        logic signed [23:0] want;
        int burst;
        bit hold_done;
        build_rom();
        err_count = 0; sent_count = 0; got_count = 0; cfg_count = 0; rx_hold = 1'b0;
        hold_done = 1'b0;
        wave_sel = WAVE_SINE; phase_step = '0; harm_cnt = 7'd2;
        duty_20 = 5'd10; qbits = 5'd4; gain_pct = 7'd50; osc_phase = '0;
        i_valid = 1'b0; i_restart_phase = 1'b0;
        i_cfg_we = 1'b0; i_cfg_addr = CFG_WAVEFORM; i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: first row runs on reset defaults
        foreach (dir_rows[j]) begin
            r = dir_rows[j];
            if (j != 0) begin
                drain();
                cfg_write(CFG_WAVEFORM, 32'(r.wv));
                cfg_write(CFG_PHASE_INC, r.inc);
                cfg_write(CFG_HARMONICS, 32'(r.hc));
                cfg_write(CFG_DUTY, 32'(r.dt));
                cfg_write(CFG_QBITS, 32'(r.qb));
                cfg_write(CFG_AMPLITUDE, 32'(r.ap));
                i_cfg_we <= 1'b0;
            end
            for (int k = 0; k < 3; k++) begin
                send_tick(k == 0 ? r.rs : 1'b0, rand_gap());
                want = pending_samples[$];
                if (r.known && k == 0 && want !== r.want)
                    report("table", want, r.want);
            end
        end

        // random part: phases of random settings, most with small harmonic counts
        while (sent_count < 850) begin
            drain();
            cfg_write(CFG_WAVEFORM, $urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                              : $urandom_range(0, 4));
            cfg_write(CFG_PHASE_INC, $urandom());
            cfg_write(CFG_HARMONICS, $urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                               : $urandom_range(1, 12));
            cfg_write(CFG_DUTY, $urandom_range(0, 31));
            cfg_write(CFG_QBITS, $urandom_range(0, 31));
            cfg_write(CFG_AMPLITUDE, $urandom_range(0, 127));
            i_cfg_we <= 1'b0;
            burst = $urandom_range(10, 40);
            // one phase where the receiver stalls long and the sender keeps offering
            if (sent_count > 300 && !hold_done) begin
                rx_hold   = 1'b1;
                hold_done = 1'b1;
            end
            for (int k = 0; k < burst; k++)
                send_tick($urandom_range(0, 15) == 0, (k % 8 < 3) ? 0 : rand_gap());
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d sample ticks over %0d register writes, %0d samples checked",
                 sent_count, cfg_count, got_count);
        $display("all waveform codes, gain, duty, depth and harmonic extremes exercised");
        if (err_count == 0 && pending_samples.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
